// ----- sv/lcpe_pkg.sv -----
// shared types, constants and arithmetic helpers for the pair energy block
`default_nettype none

package lcpe_pkg;

    // field and register widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BOX_W   = 31;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    // reset box length, 32.0 in unsigned Q15.16
    localparam logic [BOX_W-1:0] BOX_RESET = 31'd2097152;

    // coulomb constant 332.06 in Q32.32
    localparam logic [63:0] COUL_K = 64'd1426186840310;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_BOX_X = 2'd0,
        CFG_BOX_Y = 2'd1,
        CFG_BOX_Z = 2'd2
    } t_cfg_idx;

    // one atom as carried through the queue
    typedef struct packed {
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] sigma;
        logic [WORD_W-1:0] epsilon;
        logic [WORD_W-1:0] charge;
    } t_atom;

    // classified work for the back end
    typedef struct packed {
        logic  do_pair;
        logic  last;
        t_atom a1;
        t_atom a2;
    } t_job;

    // periodic box lengths
    typedef struct packed {
        logic [BOX_W-1:0] x;
        logic [BOX_W-1:0] y;
        logic [BOX_W-1:0] z;
    } t_box;

    // back end sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_AXIS,
        S_AXADD,
        S_SSMUL,
        S_SSDIV,
        S_T,
        S_TT,
        S_T3,
        S_T6,
        S_EEMUL,
        S_EESQ,
        S_LJMUL,
        S_LJ,
        S_R2SQ,
        S_R,
        S_QMUL,
        S_QDIV,
        S_CO,
        S_FIN,
        S_MUL,
        S_DIV,
        S_SQRT
    } t_state;

    // signed value from sign and magnitude, clamped to 64-bit range
    function automatic logic [63:0] to_signed(input logic neg, input logic [63:0] mag);
        logic [63:0] res;
        if (!neg) begin
            res = mag[63] ? S64_MAX : mag;
        end else begin
            res = mag[63] ? S64_MIN : (~mag + 64'd1);
        end
        return res;
    endfunction

    // saturating signed add
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [63:0] res;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            res = s[64] ? S64_MIN : S64_MAX;
        end else begin
            res = s[63:0];
        end
        return res;
    endfunction

    // saturating unsigned add
    function automatic logic [63:0] add_sat_u(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/lj_coulomb_pair_energy_sum.sv -----
// Lennard-Jones plus Coulomb pair energy accumulator, top level
//
// Input channel (i_in_valid / o_in_stall): cmd 0 stores a first-molecule atom,
// cmd 1 pairs the given atom with the stored one and adds its energy to the sum.
// A transaction with last set emits the running total on the output channel
// (o_out_valid / i_out_stall) and clears the sum.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the box
// lengths by index; a running pair reads them, so write only with nothing in flight.
// A front end classifies transactions into a two-entry queue; the back end runs
// each pair on one shared 32x32 multiplier, a radix-2 divider and a bit-serial
// square root. The work of a counted pair is mostly two 64-step divides, two
// 64-step roots and five wide products. Store items and excluded pairs go
// straight to the finish state, and a zero-distance pair skips the energy terms.
// The total is loaded into the output register in the finish state.
// Reset (synchronous, active low) clears the stored atom, the sum, the queue
// and sets every box length to 32.0. While the receiver stalls the total holds
// in the output register; the queue still fills and then stalls the input.
`default_nettype none

module lj_coulomb_pair_energy_sum #(
    parameter int unsigned QUEUE_DEPTH = lcpe_pkg::QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_cmd,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_pos_x,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_pos_y,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_pos_z,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_sigma,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_epsilon,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_charge,
    input  wire logic                               i_last,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [lcpe_pkg::ACC_W-1:0]       o_energy,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [lcpe_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire logic [lcpe_pkg::BOX_W-1:0]         i_cfg_data
);

    lcpe_pkg::t_box r_box;
    lcpe_pkg::t_job push_job, pop_job;
    logic           push, full, pop, empty;

    assign o_cfg_ready = 1'b1;

    // box length registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '{x: lcpe_pkg::BOX_RESET, y: lcpe_pkg::BOX_RESET,
                       z: lcpe_pkg::BOX_RESET};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (lcpe_pkg::t_cfg_idx'(i_cfg_index))
                lcpe_pkg::CFG_BOX_X: r_box.x <= i_cfg_data;
                lcpe_pkg::CFG_BOX_Y: r_box.y <= i_cfg_data;
                lcpe_pkg::CFG_BOX_Z: r_box.z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end
    lcpe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_sigma    (i_sigma),
        .i_epsilon  (i_epsilon),
        .i_charge   (i_charge),
        .i_last     (i_last),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // job queue
    lcpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_job),
        .o_empty (empty)
    );

    // back end
    lcpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (r_box),
        .i_empty     (empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_energy    (o_energy)
    );

endmodule

`default_nettype wire

// ----- sv/lcpe_fifo.sv -----
// short job queue between front and back end
`default_nettype none

module lcpe_fifo #(
    parameter int unsigned DEPTH = lcpe_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lcpe_pkg::t_job i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output lcpe_pkg::t_job      o_data,
    output logic                o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lcpe_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lcpe_front.sv -----
// front end: takes items, holds the first-molecule atom, classifies pairs
`default_nettype none

module lcpe_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_cmd,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_pos_x,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_pos_y,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_pos_z,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_sigma,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_epsilon,
    input  wire logic signed [lcpe_pkg::WORD_W-1:0] i_charge,
    input  wire logic                         i_last,
    input  wire logic                         i_full,
    output logic                              o_push,
    output lcpe_pkg::t_job                    o_job
);

    lcpe_pkg::t_atom r_atom;
    lcpe_pkg::t_atom in_atom;
    logic            excluded;

    assign in_atom = '{pos_x: i_pos_x, pos_y: i_pos_y, pos_z: i_pos_z,
                       sigma: i_sigma, epsilon: i_epsilon, charge: i_charge};

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    // any negative sigma or epsilon drops the pair
    assign excluded = r_atom.sigma[31] | r_atom.epsilon[31] | i_sigma[31] | i_epsilon[31];

    assign o_job = '{do_pair: i_cmd && !excluded, last: i_last, a1: r_atom, a2: in_atom};

    // stored first-molecule atom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atom <= '0;
        end else if (o_push && !i_cmd) begin
            r_atom <= in_atom;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lcpe_back.sv -----
// back end: sequencer over a shared multiplier, divider and square root
`default_nettype none

module lcpe_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lcpe_pkg::t_box i_box,
    input  wire logic           i_empty,
    input  wire lcpe_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic signed [lcpe_pkg::ACC_W-1:0] o_energy
);

    lcpe_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic               r_ovalid, n_ovalid;
    logic [63:0]        r_acc, n_acc;

    lcpe_pkg::t_job r_job, n_job;
    logic [63:0]  r_energy, n_energy;
    logic [63:0]  r_r2, n_r2, r_pp, n_pp;
    logic         r_sat, n_sat;
    logic [1:0]   r_axis, n_axis;
    logic [63:0]  r_ma, n_ma, r_mb, n_mb;
    logic [127:0] r_mp, n_mp;
    logic [6:0]   r_psh, n_psh;
    logic [2:0]   r_cnt, n_cnt;
    logic [65:0]  r_rem, n_rem;
    logic [127:0] r_num, n_num;
    logic [63:0]  r_q, n_q, r_d, n_d;
    logic [5:0]   r_it, n_it;
    logic [63:0]  r_t, n_t, r_t3, n_t3, r_mag, n_mag;
    logic         r_lneg, n_lneg;

    logic [31:0]  mul_a, mul_b;
    logic [63:0]  m_prod, qm, lj4;
    logic [31:0]  ax_p1, ax_p2, aq1, aq2;
    logic [30:0]  ax_len;
    logic signed [34:0] ax_d0, ax_d1, ax_d2, ax_l;
    logic [34:0]  ax_m;
    logic [64:0]  div_rem;
    logic [67:0]  sq_rem, sq_trial;

    assign o_out_valid = r_ovalid;
    assign o_energy    = r_energy;
    assign m_prod      = mul_a * mul_b;

    // q32.32 product from the wide result, saturating
    assign qm  = (r_mp[127:96] != '0) ? '1 : r_mp[95:32];
    assign lj4 = (qm[63:62] != '0) ? '1 : {qm[61:0], 2'b00};

    // charge magnitudes
    assign aq1 = r_job.a1.charge[31] ? (~r_job.a1.charge + 32'd1) : r_job.a1.charge;
    assign aq2 = r_job.a2.charge[31] ? (~r_job.a2.charge + 32'd1) : r_job.a2.charge;

    // minimum image along the current axis
    always_comb begin
        unique case (r_axis)
            2'd0:    begin ax_p1 = r_job.a1.pos_x; ax_p2 = r_job.a2.pos_x; ax_len = i_box.x; end
            2'd1:    begin ax_p1 = r_job.a1.pos_y; ax_p2 = r_job.a2.pos_y; ax_len = i_box.y; end
            default: begin ax_p1 = r_job.a1.pos_z; ax_p2 = r_job.a2.pos_z; ax_len = i_box.z; end
        endcase
        ax_l  = {4'b0, ax_len};
        ax_d0 = {{3{ax_p2[31]}}, ax_p2} - {{3{ax_p1[31]}}, ax_p1};
        ax_d1 = ((ax_d0 <<< 1) < -ax_l) ? ax_d0 + ax_l : ax_d0;
        ax_d2 = ((ax_d1 <<< 1) > ax_l) ? ax_d1 - ax_l : ax_d1;
        ax_m  = ax_d2[34] ? unsigned'(-ax_d2) : unsigned'(ax_d2);
    end

    // divider and square root trial steps
    assign div_rem  = {r_rem[63:0], r_num[127]};
    assign sq_rem   = {r_rem, r_num[127:126]};
    assign sq_trial = {2'b00, r_q, 2'b01};

    // sequencer next state and datapath
    always_comb begin
        n_state = r_state;  n_ret = r_ret;   n_ovalid = r_ovalid; n_acc = r_acc;
        n_job = r_job;      n_energy = r_energy;
        n_r2 = r_r2;        n_pp = r_pp;     n_sat = r_sat;       n_axis = r_axis;
        n_ma = r_ma;        n_mb = r_mb;     n_mp = r_mp;         n_psh = r_psh;
        n_cnt = r_cnt;      n_rem = r_rem;   n_num = r_num;       n_q = r_q;
        n_d = r_d;          n_it = r_it;     n_t = r_t;           n_t3 = r_t3;
        n_mag = r_mag;      n_lneg = r_lneg;
        mul_a = r_ma[31:0]; mul_b = r_mb[31:0];
        o_pop = 1'b0;

        // result register drains independently
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            lcpe_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_job  = i_job;
                    n_r2   = '0;
                    n_axis = 2'd0;
                    n_state = i_job.do_pair ? lcpe_pkg::S_AXIS : lcpe_pkg::S_FIN;
                end
            end
            // squared axis distance
            lcpe_pkg::S_AXIS: begin
                mul_a   = ax_m[31:0];
                mul_b   = ax_m[31:0];
                n_pp    = m_prod;
                n_sat   = (ax_m[34:32] != '0);
                n_state = lcpe_pkg::S_AXADD;
            end
            lcpe_pkg::S_AXADD: begin
                n_r2 = lcpe_pkg::add_sat_u(r_r2, r_sat ? '1 : r_pp);
                if (r_axis == 2'd2) begin
                    n_state = lcpe_pkg::S_SSMUL;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = lcpe_pkg::S_AXIS;
                end
            end
            // sigma product, or skip on zero distance
            lcpe_pkg::S_SSMUL: begin
                mul_a = r_job.a1.sigma;
                mul_b = r_job.a2.sigma;
                n_pp  = m_prod;
                n_state = (r_r2 == '0) ? lcpe_pkg::S_FIN : lcpe_pkg::S_SSDIV;
            end
            lcpe_pkg::S_SSDIV: begin
                n_d   = r_r2;
                n_rem = {34'b0, r_pp[63:32]};
                n_num = {r_pp[31:0], 96'b0};
                n_q   = '0;
                n_it  = '0;
                n_ret = lcpe_pkg::S_T;
                if ({32'b0, r_pp[63:32]} >= r_r2) begin
                    n_q     = '1;
                    n_state = lcpe_pkg::S_T;
                end else begin
                    n_state = lcpe_pkg::S_DIV;
                end
            end
            // powers of the ratio
            lcpe_pkg::S_T: begin
                n_t = r_q;  n_ma = r_q;  n_mb = r_q;
                n_mp = '0;  n_cnt = '0;
                n_ret = lcpe_pkg::S_TT;
                n_state = lcpe_pkg::S_MUL;
            end
            lcpe_pkg::S_TT: begin
                n_ma = qm;  n_mb = r_t;
                n_mp = '0;  n_cnt = '0;
                n_ret = lcpe_pkg::S_T3;
                n_state = lcpe_pkg::S_MUL;
            end
            lcpe_pkg::S_T3: begin
                n_t3 = qm;  n_ma = qm;  n_mb = qm;
                n_mp = '0;  n_cnt = '0;
                n_ret = lcpe_pkg::S_T6;
                n_state = lcpe_pkg::S_MUL;
            end
            lcpe_pkg::S_T6: begin
                n_lneg  = (qm < r_t3);
                n_mag   = (qm < r_t3) ? r_t3 - qm : qm - r_t3;
                n_state = lcpe_pkg::S_EEMUL;
            end
            // epsilon blending
            lcpe_pkg::S_EEMUL: begin
                mul_a = r_job.a1.epsilon;
                mul_b = r_job.a2.epsilon;
                n_pp  = m_prod;
                n_state = lcpe_pkg::S_EESQ;
            end
            lcpe_pkg::S_EESQ: begin
                n_num = {32'b0, r_pp, 32'b0};
                n_rem = '0;  n_q = '0;  n_it = '0;
                n_ret = lcpe_pkg::S_LJMUL;
                n_state = lcpe_pkg::S_SQRT;
            end
            lcpe_pkg::S_LJMUL: begin
                n_ma = r_q;  n_mb = r_mag;
                n_mp = '0;   n_cnt = '0;
                n_ret = lcpe_pkg::S_LJ;
                n_state = lcpe_pkg::S_MUL;
            end
            lcpe_pkg::S_LJ: begin
                n_acc   = lcpe_pkg::sat_add(r_acc, lcpe_pkg::to_signed(r_lneg, lj4));
                n_state = lcpe_pkg::S_R2SQ;
            end
            // distance for the coulomb term
            lcpe_pkg::S_R2SQ: begin
                n_num = {32'b0, r_r2, 32'b0};
                n_rem = '0;  n_q = '0;  n_it = '0;
                n_ret = lcpe_pkg::S_R;
                n_state = lcpe_pkg::S_SQRT;
            end
            lcpe_pkg::S_R: begin
                n_d   = r_q;
                mul_a = aq1;
                mul_b = aq2;
                n_pp  = m_prod;
                n_state = lcpe_pkg::S_QMUL;
            end
            lcpe_pkg::S_QMUL: begin
                n_ma = r_pp;  n_mb = lcpe_pkg::COUL_K;
                n_mp = '0;    n_cnt = '0;
                n_ret = lcpe_pkg::S_QDIV;
                n_state = lcpe_pkg::S_MUL;
            end
            lcpe_pkg::S_QDIV: begin
                n_rem = {2'b0, r_mp[127:64]};
                n_num = {r_mp[63:0], 64'b0};
                n_q   = '0;
                n_it  = '0;
                n_ret = lcpe_pkg::S_CO;
                if (r_mp[127:64] >= r_d) begin
                    n_q     = '1;
                    n_state = lcpe_pkg::S_CO;
                end else begin
                    n_state = lcpe_pkg::S_DIV;
                end
            end
            lcpe_pkg::S_CO: begin
                n_acc = lcpe_pkg::sat_add(r_acc, lcpe_pkg::to_signed(
                            r_job.a1.charge[31] ^ r_job.a2.charge[31], r_q));
                n_state = lcpe_pkg::S_FIN;
            end
            // emit the total on the last item
            lcpe_pkg::S_FIN: begin
                if (!r_job.last) begin
                    n_state = lcpe_pkg::S_IDLE;
                end else if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_energy = r_acc;
                    n_acc    = '0;
                    n_state  = lcpe_pkg::S_IDLE;
                end
            end
            // 64x64 product over four 32x32 partial products
            lcpe_pkg::S_MUL: begin
                mul_a = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
                mul_b = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];
                if (r_cnt != 3'd4) begin
                    n_pp  = m_prod;
                    n_psh = {r_cnt[1] & r_cnt[0], r_cnt[1] ^ r_cnt[0], 5'b0};
                end
                if (r_cnt != 3'd0) begin
                    n_mp = r_mp + ({64'b0, r_pp} << r_psh);
                end
                if (r_cnt == 3'd4) begin
                    n_state = r_ret;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            // restoring divide, one quotient bit a cycle
            lcpe_pkg::S_DIV: begin
                n_num = {r_num[126:0], 1'b0};
                if (div_rem >= {1'b0, r_d}) begin
                    n_rem = {2'b0, 64'(div_rem - {1'b0, r_d})};
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = {1'b0, div_rem};
                    n_q   = {r_q[62:0], 1'b0};
                end
                n_it = r_it + 6'd1;
                if (r_it == 6'd63) begin
                    n_state = r_ret;
                end
            end
            // integer square root, one root bit a cycle
            lcpe_pkg::S_SQRT: begin
                n_num = {r_num[125:0], 2'b00};
                if (sq_rem >= sq_trial) begin
                    n_rem = 66'(sq_rem - sq_trial);
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = 66'(sq_rem);
                    n_q   = {r_q[62:0], 1'b0};
                end
                n_it = r_it + 6'd1;
                if (r_it == 6'd63) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = lcpe_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lcpe_pkg::S_IDLE;
            r_ret    <= lcpe_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_ovalid <= n_ovalid;
            r_acc    <= n_acc;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_job <= n_job;   r_energy <= n_energy;
        r_r2  <= n_r2;    r_pp  <= n_pp;   r_sat <= n_sat;  r_axis <= n_axis;
        r_ma  <= n_ma;    r_mb  <= n_mb;   r_mp  <= n_mp;   r_psh  <= n_psh;
        r_cnt <= n_cnt;   r_rem <= n_rem;  r_num <= n_num;  r_q    <= n_q;
        r_d   <= n_d;     r_it  <= n_it;   r_t   <= n_t;    r_t3   <= n_t3;
        r_mag <= n_mag;   r_lneg <= n_lneg;
    end

endmodule

`default_nettype wire
